[sv/salwc_pkg.sv]
// ----------------------------------------------------------------------------
// salwc_pkg
// shared constants, configuration register codes and sequencer states for
// the set-associative write-back cache core
// ----------------------------------------------------------------------------
package salwc_pkg;

    localparam int unsigned MAX_SETS_DEF = 256;
    localparam int unsigned MAX_WAYS_DEF = 8;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned WAY_OUT_W = 3;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd3;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd4;
    localparam logic [CFG_W-1:0] WAYS_USED_RST   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_USED   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_DONE
    } t_state;

endpackage

[sv/salwc_req_if.sv]
// ----------------------------------------------------------------------------
// salwc_req_if
// access channel: read/write kind and byte address
// ----------------------------------------------------------------------------
interface salwc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [salwc_pkg::ADDR_W-1:0]  addr;

    modport source (output valid, output func, output addr, input ready);
    modport sink   (input valid, input func, input addr, output ready);
endinterface

[sv/salwc_rsp_if.sv]
// ----------------------------------------------------------------------------
// salwc_rsp_if
// result channel: hit, write-back, fill and way information per access
// ----------------------------------------------------------------------------
interface salwc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic                             write_back;
    logic                             filled_empty;
    logic [salwc_pkg::WAY_OUT_W-1:0]  way_hit_or_filled;
    logic [salwc_pkg::TAG_W-1:0]      victim_tag;

    modport source (output valid, output hit, output write_back, output filled_empty,
                    output way_hit_or_filled, output victim_tag, input ready);
    modport sink   (input valid, input hit, input write_back, input filled_empty,
                    input way_hit_or_filled, input victim_tag, output ready);
endinterface

[sv/salwc_ram.sv]
// ----------------------------------------------------------------------------
// salwc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module salwc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/set_assoc_lru_writeback_cache_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_core
// tag-only set-associative write-back write-allocate cache with lru ranks
// one item at a time: a new item is taken only once the last result is loaded
// into the result register; each tag ram access covers one way, and each way
// is read in a scan pass, then read and written in an update pass
// reset: sweeps all 2^(set bits + way bits) tag ram entries to zero, one entry
// a cycle (2048 at default sizes); no item is accepted during the sweep
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_core #(
    parameter int unsigned MAX_SETS = salwc_pkg::MAX_SETS_DEF,
    parameter int unsigned MAX_WAYS = salwc_pkg::MAX_WAYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [salwc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salwc_pkg::CFG_W-1:0]      i_cfg_data,
    salwc_req_if.sink                        i_req,
    salwc_rsp_if.source                      o_rsp
);

    localparam int unsigned MAX_IB_RAW = $clog2(MAX_SETS + 1) - 1;
    localparam int unsigned MAX_IB     = (MAX_IB_RAW > 12) ? 12 : MAX_IB_RAW;
    localparam int unsigned SW         = (MAX_IB > 0) ? MAX_IB : 1;
    localparam int unsigned WW         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned RW         = WW;
    localparam int unsigned AW         = SW + WW;
    localparam int unsigned DEPTH      = 2 ** AW;
    localparam int unsigned TW         = salwc_pkg::TAG_W;
    localparam int unsigned REC_W      = TW + 2 + RW;
    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

    // configuration
    logic [3:0] r_offset_bits;
    logic [3:0] r_index_bits;
    logic [3:0] r_ways_used;

    // sequencer and datapath registers
    salwc_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic              r_func;
    logic [SW-1:0]     r_set;
    logic [TW-1:0]     r_tag;
    logic [WW-1:0]     r_way;
    logic [WW-1:0]     r_last;
    logic              r_hit;
    logic [WW-1:0]     r_hit_way;
    logic [RW-1:0]     r_hit_rank;
    logic              r_empty;
    logic [WW-1:0]     r_empty_way;
    logic [RW-1:0]     r_best;
    logic [WW-1:0]     r_vic_way;
    logic              r_vic_dirty;
    logic [TW-1:0]     r_vic_tag;
    logic [WW-1:0]     r_tgt_way;
    logic              r_tgt_valid;
    logic [RW-1:0]     r_old_rank;
    logic              r_wb;
    logic [TW-1:0]     r_vtag;

    // result register
    logic                                r_out_valid;
    logic                                r_out_hit;
    logic                                r_out_wb;
    logic                                r_out_empty;
    logic [salwc_pkg::WAY_OUT_W-1:0]     r_out_way;
    logic [TW-1:0]                       r_out_vtag;

    // combinational
    logic              w_accept;
    logic              w_req_ready;
    logic              w_load_out;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [AW-1:0]     w_ram_raddr;
    logic [REC_W-1:0]  w_ram_wdata;
    logic [REC_W-1:0]  w_ram_rdata;
    logic [3:0]        w_ib;
    logic [SW-1:0]     w_set_mask;
    logic [TW-1:0]     w_addr_sh;
    logic [4:0]        w_tag_sh;
    logic [SW-1:0]     w_set;
    logic [TW-1:0]     w_tag;
    logic [4:0]        w_nw;
    logic [4:0]        w_nw_m1;
    logic [TW-1:0]     w_rd_tag;
    logic              w_rd_valid;
    logic              w_rd_dirty;
    logic [RW-1:0]     w_rd_rank;
    logic              w_last_way;
    logic [REC_W-1:0]  w_upd_rec;
    logic [WW+2:0]     w_way_ext;

    salwc_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // address split and way count
    always_comb begin
        w_ib       = (r_index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : r_index_bits;
        w_set_mask = ~({SW{1'b1}} << w_ib);
        w_addr_sh  = i_req.addr >> r_offset_bits;
        w_set      = w_addr_sh[SW-1:0] & w_set_mask;
        w_tag_sh   = {1'b0, r_offset_bits} + {1'b0, w_ib};
        w_tag      = i_req.addr >> w_tag_sh;
        if (r_ways_used == 4'd0) begin
            w_nw = 5'd1;
        end else if ({1'b0, r_ways_used} > 5'(MAX_WAYS)) begin
            w_nw = 5'(MAX_WAYS);
        end else begin
            w_nw = {1'b0, r_ways_used};
        end
        w_nw_m1 = w_nw - 5'd1;
    end

    assign w_rd_tag   = w_ram_rdata[REC_W-1:RW+2];
    assign w_rd_valid = w_ram_rdata[RW+1];
    assign w_rd_dirty = w_ram_rdata[RW];
    assign w_rd_rank  = w_ram_rdata[RW-1:0];
    assign w_last_way = (r_way == r_last);
    assign w_accept   = i_req.valid && w_req_ready;

    // rank and line update for the way under the read data
    always_comb begin
        w_upd_rec = w_ram_rdata;
        if (r_way == r_tgt_way) begin
            w_upd_rec[REC_W-1:RW+2] = r_tag;
            w_upd_rec[RW+1]         = 1'b1;
            w_upd_rec[RW]           = r_hit ? (w_rd_dirty | r_func) : r_func;
            w_upd_rec[RW-1:0]       = '0;
        end else if (w_rd_valid && (!r_tgt_valid || (w_rd_rank < r_old_rank))
                     && (w_rd_rank != RANK_MAX)) begin
            w_upd_rec[RW-1:0] = w_rd_rank + RW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            salwc_pkg::ST_CLEAR: begin
                if (r_clr == {AW{1'b1}}) n_state = salwc_pkg::ST_IDLE;
            end
            salwc_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = salwc_pkg::ST_SCAN_RD;
            end
            salwc_pkg::ST_SCAN_RD:  n_state = salwc_pkg::ST_SCAN_CMP;
            salwc_pkg::ST_SCAN_CMP: begin
                n_state = w_last_way ? salwc_pkg::ST_DECIDE : salwc_pkg::ST_SCAN_RD;
            end
            salwc_pkg::ST_DECIDE:   n_state = salwc_pkg::ST_UPD_RD;
            salwc_pkg::ST_UPD_RD:   n_state = salwc_pkg::ST_UPD_WR;
            salwc_pkg::ST_UPD_WR: begin
                n_state = w_last_way ? salwc_pkg::ST_DONE : salwc_pkg::ST_UPD_RD;
            end
            salwc_pkg::ST_DONE: begin
                if (w_load_out) n_state = salwc_pkg::ST_IDLE;
            end
            default: n_state = salwc_pkg::ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_req_ready = 1'b0;
        w_load_out  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = {r_set, r_way};
        w_ram_raddr = {r_set, r_way};
        w_ram_wdata = w_upd_rec;
        case (r_state)
            salwc_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
            end
            salwc_pkg::ST_IDLE:   w_req_ready = 1'b1;
            salwc_pkg::ST_UPD_WR: w_ram_we = 1'b1;
            salwc_pkg::ST_DONE:   w_load_out = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= salwc_pkg::ST_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_offset_bits <= salwc_pkg::OFFSET_BITS_RST;
            r_index_bits  <= salwc_pkg::INDEX_BITS_RST;
            r_ways_used   <= salwc_pkg::WAYS_USED_RST;
        end else begin
            r_state <= n_state;
            if (r_state == salwc_pkg::ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    salwc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                    salwc_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                    salwc_pkg::CFG_WAYS_USED:   r_ways_used   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_req.func;
            r_set   <= w_set;
            r_tag   <= w_tag;
            r_last  <= w_nw_m1[WW-1:0];
            r_way   <= '0;
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
            r_best  <= '0;
        end
        if (r_state == salwc_pkg::ST_SCAN_CMP) begin
            if (!r_hit && w_rd_valid && (w_rd_tag == r_tag)) begin
                r_hit      <= 1'b1;
                r_hit_way  <= r_way;
                r_hit_rank <= w_rd_rank;
            end
            if (!r_empty && !w_rd_valid) begin
                r_empty     <= 1'b1;
                r_empty_way <= r_way;
            end
            if (w_rd_rank >= r_best) begin
                r_best      <= w_rd_rank;
                r_vic_way   <= r_way;
                r_vic_dirty <= w_rd_dirty;
                r_vic_tag   <= w_rd_tag;
            end
            r_way <= w_last_way ? '0 : r_way + WW'(1);
        end
        if (r_state == salwc_pkg::ST_DECIDE) begin
            if (r_hit) begin
                r_tgt_way   <= r_hit_way;
                r_tgt_valid <= 1'b1;
                r_old_rank  <= r_hit_rank;
                r_wb        <= 1'b0;
                r_vtag      <= '0;
            end else if (r_empty) begin
                r_tgt_way   <= r_empty_way;
                r_tgt_valid <= 1'b0;
                r_old_rank  <= RANK_MAX;
                r_wb        <= 1'b0;
                r_vtag      <= '0;
            end else begin
                r_tgt_way   <= r_vic_way;
                r_tgt_valid <= 1'b1;
                r_old_rank  <= r_best;
                r_wb        <= r_vic_dirty;
                r_vtag      <= r_vic_dirty ? r_vic_tag : '0;
            end
        end
        if (r_state == salwc_pkg::ST_UPD_WR) r_way <= r_way + WW'(1);
        if (w_load_out) begin
            r_out_hit   <= r_hit;
            r_out_wb    <= r_wb;
            r_out_empty <= !r_hit && r_empty;
            r_out_way   <= w_way_ext[salwc_pkg::WAY_OUT_W-1:0];
            r_out_vtag  <= r_vtag;
        end
    end

    assign w_way_ext = {3'b000, r_tgt_way};

    assign i_req.ready             = w_req_ready;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.hit               = r_out_hit;
    assign o_rsp.write_back        = r_out_wb;
    assign o_rsp.filled_empty      = r_out_empty;
    assign o_rsp.way_hit_or_filled = r_out_way;
    assign o_rsp.victim_tag        = r_out_vtag;

    // checks
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.filled_empty))
        else $error("hit and empty fill reported together");

    a_wb_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.write_back) |-> (!o_rsp.hit && !o_rsp.filled_empty))
        else $error("write-back without eviction");

    a_vtag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.write_back) |-> (o_rsp.victim_tag == '0))
        else $error("victim tag set without write-back");

    a_ram_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == salwc_pkg::ST_CLEAR) || (r_state == salwc_pkg::ST_UPD_WR)))
        else $error("tag ram written outside clear or update");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == salwc_pkg::ST_SCAN_RD))
        else $error("accepted item did not start the set scan");

endmodule
